// File: hw/rtl/rotation_accumulate_vertex_transform_core_defines.svh
// ----------------------------------------------------------------------------
// Rotation/vertex transform assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATION_ACCUMULATE_VERTEX_TRANSFORM_CORE_DEFINES_SVH
`define ROTATION_ACCUMULATE_VERTEX_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication
`define RAVT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ravt_pkg.sv
// ----------------------------------------------------------------------------
// ravt_pkg
// Types and constants shared by the rotation/vertex transform core.
// ----------------------------------------------------------------------------
package ravt_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int COORD_W         = 24;
  localparam int ANGLE_W         = 16;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic                      action;
    logic [ANGLE_W-1:0]        angle_x;
    logic [ANGLE_W-1:0]        angle_y;
    logic [ANGLE_W-1:0]        angle_z;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
  } ravt_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] tz;
  } ravt_out_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } ravt_acc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_TLD,
    ST_MUL,
    ST_ACC,
    ST_WR,
    ST_COMMIT,
    ST_OUT
  } ravt_state_t;

  typedef struct packed {
    logic         in_ld;
    logic         rom_rd;
    logic         trig_ld;
    logic         mul_en;
    ravt_acc_op_t acc_op;
    logic         wr_en;
    logic         commit;
    logic         out_ld;
    logic         rot;
    logic [1:0]   axis;
    logic [1:0]   i;
    logic [1:0]   j;
    logic [1:0]   k;
  } ravt_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic action;
    logic out_free;
  } ravt_sts_t;

endpackage

// File: hw/rtl/ravt_dp.sv
// ----------------------------------------------------------------------------
// ravt_dp
// Datapath: matrix store, quarter-wave sine ROM, shared MAC, round/saturate.
// ----------------------------------------------------------------------------
`include "rotation_accumulate_vertex_transform_core_defines.svh"

module ravt_dp #(
  parameter int FRAC_BITS        = ravt_pkg::FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = ravt_pkg::SINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ravt_pkg::ravt_cmd_t cmd,
  input  ravt_pkg::ravt_in_t  in_data,
  input  logic                out_ready,
  output logic                out_free,
  output logic                out_valid,
  output ravt_pkg::ravt_out_t out_data
);

  localparam int MW = FRAC_BITS + 2;
  localparam int VW = ravt_pkg::COORD_W;
  localparam int BW = (VW > MW) ? VW : MW;
  localparam int PW = MW + BW;
  localparam int AW = PW + 2;
  localparam int DB = $clog2(SINE_TABLE_DEPTH);
  localparam int QB = DB - 2;
  localparam int QD = SINE_TABLE_DEPTH / 4;
  localparam int RS = 30 - FRAC_BITS;

  localparam logic signed [MW-1:0] ONE    = MW'(1) << FRAC_BITS;
  localparam logic signed [AW-1:0] HALF   = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] M_HI   = (AW'(1) << (FRAC_BITS + 1)) - AW'(1);
  localparam logic signed [AW-1:0] M_LO   = ~M_HI;
  localparam logic signed [AW-1:0] V_HI   = AW'(24'h7FFFFF);
  localparam logic signed [AW-1:0] V_LO   = ~V_HI;

  typedef logic [FRAC_BITS:0] rom_t [QD+1];

  function automatic rom_t build_rom();
    rom_t              t;
    longint unsigned   r;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint unsigned   mag;
    for (int m = 0; m <= QD; m++) begin
      r    = 64'(m) << (30 - QB);
      x    = (r * 64'd1686629713) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > 64'sd1073741824) begin
        sum = 64'sd1073741824;
      end
      mag  = (64'(sum) + ((64'd1 << RS) >> 1)) >> RS;
      t[m] = (FRAC_BITS + 1)'(mag);
    end
    return t;
  endfunction

  localparam rom_t SIN_ROM = build_rom();

  ravt_pkg::ravt_in_t       in_r;
  logic signed [MW-1:0]     mat_r [9];
  logic signed [MW-1:0]     tmp_r [9];
  logic signed [VW-1:0]     res_r [3];
  logic [FRAC_BITS:0]       smag_r, cmag_r;
  logic                     sneg_r, cneg_r;
  logic signed [MW-1:0]     sin_r, cos_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [AW-1:0]     acc_r;
  logic                     out_valid_r;
  ravt_pkg::ravt_out_t      out_data_r;

  logic [ravt_pkg::ANGLE_W-1:0] ang;
  logic [DB-1:0]            idx_s, idx_c;
  logic [QB:0]              m_s, m_c;
  logic signed [MW-1:0]     relem;
  logic [3:0]               m_idx;
  logic [3:0]               w_idx;
  logic signed [MW-1:0]     m_op;
  logic signed [BW-1:0]     b_op;
  logic signed [VW-1:0]     v_k;
  logic signed [AW-1:0]     rnd;
  logic signed [MW-1:0]     sat_m;
  logic signed [VW-1:0]     sat_v;

  always_comb begin
    unique case (cmd.axis)
      ravt_pkg::AXIS_X: ang = in_r.angle_x;
      ravt_pkg::AXIS_Y: ang = in_r.angle_y;
      default:          ang = in_r.angle_z;
    endcase
    idx_s = ang[ravt_pkg::ANGLE_W-1 -: DB];
    idx_c = idx_s + DB'(QD);
    m_s   = idx_s[DB-2] ? ((QB+1)'(QD) - {1'b0, idx_s[QB-1:0]}) : {1'b0, idx_s[QB-1:0]};
    m_c   = idx_c[DB-2] ? ((QB+1)'(QD) - {1'b0, idx_c[QB-1:0]}) : {1'b0, idx_c[QB-1:0]};
  end

  always_comb begin
    relem = '0;
    unique case (cmd.axis)
      ravt_pkg::AXIS_X: begin
        if (cmd.k == 2'd0 && cmd.j == 2'd0) relem = ONE;
        if (cmd.k == 2'd1 && cmd.j == 2'd1) relem = cos_r;
        if (cmd.k == 2'd1 && cmd.j == 2'd2) relem = sin_r;
        if (cmd.k == 2'd2 && cmd.j == 2'd1) relem = -sin_r;
        if (cmd.k == 2'd2 && cmd.j == 2'd2) relem = cos_r;
      end
      ravt_pkg::AXIS_Y: begin
        if (cmd.k == 2'd0 && cmd.j == 2'd0) relem = cos_r;
        if (cmd.k == 2'd0 && cmd.j == 2'd2) relem = -sin_r;
        if (cmd.k == 2'd1 && cmd.j == 2'd1) relem = ONE;
        if (cmd.k == 2'd2 && cmd.j == 2'd0) relem = sin_r;
        if (cmd.k == 2'd2 && cmd.j == 2'd2) relem = cos_r;
      end
      default: begin
        if (cmd.k == 2'd0 && cmd.j == 2'd0) relem = cos_r;
        if (cmd.k == 2'd0 && cmd.j == 2'd1) relem = sin_r;
        if (cmd.k == 2'd1 && cmd.j == 2'd0) relem = -sin_r;
        if (cmd.k == 2'd1 && cmd.j == 2'd1) relem = cos_r;
        if (cmd.k == 2'd2 && cmd.j == 2'd2) relem = ONE;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.k)
      2'd0:    v_k = in_r.vx;
      2'd1:    v_k = in_r.vy;
      default: v_k = in_r.vz;
    endcase
    if (cmd.rot) begin
      m_idx = 4'(cmd.i) * 4'd3 + 4'(cmd.k);
      b_op  = BW'(relem);
    end else begin
      m_idx = 4'(cmd.k) * 4'd3 + 4'(cmd.j);
      b_op  = BW'(v_k);
    end
    m_op  = mat_r[m_idx];
    w_idx = 4'(cmd.i) * 4'd3 + 4'(cmd.j);
    rnd   = (acc_r + HALF) >>> FRAC_BITS;
    if (rnd > M_HI) begin
      sat_m = M_HI[MW-1:0];
    end else if (rnd < M_LO) begin
      sat_m = M_LO[MW-1:0];
    end else begin
      sat_m = rnd[MW-1:0];
    end
    if (rnd > V_HI) begin
      sat_v = V_HI[VW-1:0];
    end else if (rnd < V_LO) begin
      sat_v = V_LO[VW-1:0];
    end else begin
      sat_v = rnd[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      in_r <= in_data;
    end
    if (cmd.rom_rd) begin
      smag_r <= SIN_ROM[m_s];
      cmag_r <= SIN_ROM[m_c];
      sneg_r <= idx_s[DB-1];
      cneg_r <= idx_c[DB-1];
    end
    if (cmd.trig_ld) begin
      sin_r <= sneg_r ? -MW'(smag_r) : MW'(smag_r);
      cos_r <= cneg_r ? -MW'(cmag_r) : MW'(cmag_r);
    end
    if (cmd.mul_en) begin
      prod_r <= PW'(m_op) * PW'(b_op);
    end
    unique case (cmd.acc_op)
      ravt_pkg::ACC_LOAD: acc_r <= AW'(prod_r);
      ravt_pkg::ACC_ADD:  acc_r <= acc_r + AW'(prod_r);
      default:            acc_r <= acc_r;
    endcase
    if (cmd.wr_en && cmd.rot) begin
      tmp_r[w_idx] <= sat_m;
    end
    if (cmd.wr_en && !cmd.rot) begin
      res_r[cmd.j] <= sat_v;
    end
    if (cmd.out_ld) begin
      out_data_r <= '{tx: res_r[0], ty: res_r[1], tz: res_r[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < 9; e++) begin
        mat_r[e] <= (e == 0 || e == 4 || e == 8) ? ONE : '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        mat_r <= tmp_r;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RAVT_ASSERT_SAME(a_out_ld_free, cmd.out_ld, out_free, "result loaded over a waiting item")
  `RAVT_ASSERT_NEXT(a_trig_after_rom, cmd.rom_rd, cmd.trig_ld, "trig load did not follow ROM read")
  `RAVT_ASSERT_SAME(a_wr_index, cmd.wr_en, cmd.i != 2'd3 && cmd.j != 2'd3, "element index out of range")

endmodule

// File: hw/rtl/ravt_ctrl.sv
// ----------------------------------------------------------------------------
// ravt_ctrl
// Sequencer: walks rotate and vertex items through the shared MAC.
// ----------------------------------------------------------------------------
`include "rotation_accumulate_vertex_transform_core_defines.svh"

module ravt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  ravt_pkg::ravt_sts_t sts,
  output logic                in_ready,
  output ravt_pkg::ravt_cmd_t cmd
);

  ravt_pkg::ravt_state_t state_r, state_nxt;
  logic       rot_r, rot_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [1:0] i_r, i_nxt;
  logic [1:0] j_r, j_nxt;
  logic [1:0] k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    rot_nxt   = rot_r;
    axis_nxt  = axis_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      ravt_pkg::ST_IDLE: begin
        if (sts.in_valid) begin
          rot_nxt   = !sts.action;
          axis_nxt  = ravt_pkg::AXIS_X;
          i_nxt     = 2'd0;
          j_nxt     = 2'd0;
          k_nxt     = 2'd0;
          state_nxt = sts.action ? ravt_pkg::ST_MUL : ravt_pkg::ST_TRIG;
        end
      end
      ravt_pkg::ST_TRIG: state_nxt = ravt_pkg::ST_TLD;
      ravt_pkg::ST_TLD:  state_nxt = ravt_pkg::ST_MUL;
      ravt_pkg::ST_MUL: begin
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = ravt_pkg::ST_ACC;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ravt_pkg::ST_ACC: state_nxt = ravt_pkg::ST_WR;
      ravt_pkg::ST_WR: begin
        if (j_r != 2'd2) begin
          j_nxt     = j_r + 2'd1;
          state_nxt = ravt_pkg::ST_MUL;
        end else if (!rot_r) begin
          j_nxt     = 2'd0;
          state_nxt = ravt_pkg::ST_OUT;
        end else if (i_r != 2'd2) begin
          j_nxt     = 2'd0;
          i_nxt     = i_r + 2'd1;
          state_nxt = ravt_pkg::ST_MUL;
        end else begin
          j_nxt     = 2'd0;
          i_nxt     = 2'd0;
          state_nxt = ravt_pkg::ST_COMMIT;
        end
      end
      ravt_pkg::ST_COMMIT: begin
        if (axis_r == ravt_pkg::AXIS_Z) begin
          state_nxt = ravt_pkg::ST_IDLE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ravt_pkg::ST_TRIG;
        end
      end
      ravt_pkg::ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ravt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ravt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == ravt_pkg::ST_IDLE);
    cmd         = '0;
    cmd.rot     = rot_r;
    cmd.axis    = axis_r;
    cmd.i       = i_r;
    cmd.j       = j_r;
    cmd.k       = k_r;
    cmd.acc_op  = ravt_pkg::ACC_NONE;
    unique case (state_r)
      ravt_pkg::ST_IDLE:   cmd.in_ld   = sts.in_valid;
      ravt_pkg::ST_TRIG:   cmd.rom_rd  = 1'b1;
      ravt_pkg::ST_TLD:    cmd.trig_ld = 1'b1;
      ravt_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (k_r == 2'd1) begin
          cmd.acc_op = ravt_pkg::ACC_LOAD;
        end else if (k_r == 2'd2) begin
          cmd.acc_op = ravt_pkg::ACC_ADD;
        end
      end
      ravt_pkg::ST_ACC:    cmd.acc_op  = ravt_pkg::ACC_ADD;
      ravt_pkg::ST_WR:     cmd.wr_en   = 1'b1;
      ravt_pkg::ST_COMMIT: cmd.commit  = 1'b1;
      ravt_pkg::ST_OUT:    cmd.out_ld  = sts.out_free;
      default:             cmd.in_ld   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ravt_pkg::ST_IDLE;
      rot_r   <= 1'b0;
      axis_r  <= ravt_pkg::AXIS_X;
      i_r     <= 2'd0;
      j_r     <= 2'd0;
      k_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      rot_r   <= rot_nxt;
      axis_r  <= axis_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  `RAVT_ASSERT_SAME(a_commit_rot, cmd.commit, cmd.rot, "matrix commit on a vertex item")
  `RAVT_ASSERT_SAME(a_out_vertex, cmd.out_ld, !cmd.rot, "result emitted for a rotate item")
  `RAVT_ASSERT_NEXT(a_accept_busy, sts.in_valid && in_ready, !in_ready, "accepted item did not start")

endmodule

// File: hw/rtl/rotation_accumulate_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// rotation_accumulate_vertex_transform_core
// Euler rotation matrix accumulator and vertex transform, top level.
// ----------------------------------------------------------------------------
// One item at a time, all products on a single shared multiplier followed
// by an accumulator; each matrix element or output coordinate takes 3
// multiplies, an accumulate tail and a round/saturate write. A rotate
// item runs, after the accept, 3 axes of ROM read, sin/cos load, 9 elements
// and matrix commit. A vertex item computes its 3 coordinates, then waits
// for the output register to drain if needed. The output register
// holds a finished result while the next item is accepted.

module rotation_accumulate_vertex_transform_core #(
  parameter int FRAC_BITS        = ravt_pkg::FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = ravt_pkg::SINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ravt_pkg::ravt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ravt_pkg::ravt_out_t out_data
);

  ravt_pkg::ravt_cmd_t cmd;
  ravt_pkg::ravt_sts_t sts;
  logic                out_free;

  assign sts = '{in_valid: in_valid, action: in_data.action, out_free: out_free};

  ravt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ravt_dp #(
    .FRAC_BITS        (FRAC_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_rotation_accumulate_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// tb_rotation_accumulate_vertex_transform_core
// Drives rotate and vertex items with random gaps and output stalls and
// checks every transformed vertex against a fixed-point matrix predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rotation_accumulate_vertex_transform_core;

  localparam int FB        = ravt_pkg::FRAC_BITS_DEF;
  localparam int DEPTH     = ravt_pkg::SINE_DEPTH_DEF;
  localparam int WDOG_MAX  = 5000;
  localparam logic ACT_ROT = 1'b0;
  localparam logic ACT_VTX = 1'b1;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  ravt_pkg::ravt_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  ravt_pkg::ravt_out_t out_data;

  rotation_accumulate_vertex_transform_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ravt_pkg::ravt_in_t  pending_items[$];
  ravt_pkg::ravt_out_t expected_vertices[$];
  longint      rot_mat[9];
  int          errors;
  int          idle_cnt;
  int          in_gap;
  int          out_gap;
  int          hold_cycles;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint trig_phase(bit [31:0] ph);
    bit [1:0] quad;
    longint unsigned r, x, x2, term;
    longint sum, mag;
    int s;
    quad = ph[31:30];
    r = 64'(ph[29:0]);
    if (quad[0]) r = 64'd1073741824 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    sum = clampl(sum, 0, 64'd1073741824);
    s = 30 - FB;
    mag = (sum + (64'd1 << (s - 1))) >> s;
    return quad >= 2 ? -mag : mag;
  endfunction

  task automatic sin_cos(input bit [15:0] ang, output longint sn, output longint cs);
    longint unsigned idx;
    bit [31:0] ph;
    idx = (longint'(ang) * DEPTH) >> 16;
    ph = 32'((idx << 32) / DEPTH);
    sn = trig_phase(ph);
    cs = trig_phase(ph + 32'h4000_0000);
  endtask

  task automatic mat_post_mul(input longint r[9]);
    longint res[9];
    longint acc;
    longint hi, lo;
    hi = (64'sd1 << (FB + 1)) - 1;
    lo = -(64'sd1 <<< (FB + 1));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot_mat[i*3+k] * r[k*3+j];
        res[i*3+j] = clampl(floor_shr(acc + (64'sd1 << (FB - 1)), FB), lo, hi);
      end
    rot_mat = res;
  endtask

  task automatic predict_item(input ravt_pkg::ravt_in_t it);
    longint one, s, c, acc;
    longint r[9];
    longint v[3];
    longint t[3];
    ravt_pkg::ravt_out_t o;
    one = 64'sd1 << FB;
    if (it.action == ACT_ROT) begin
      sin_cos(it.angle_x, s, c);
      r = '{one, 0, 0, 0, c, s, 0, -s, c};
      mat_post_mul(r);
      sin_cos(it.angle_y, s, c);
      r = '{c, 0, -s, 0, one, 0, s, 0, c};
      mat_post_mul(r);
      sin_cos(it.angle_z, s, c);
      r = '{c, s, 0, -s, c, 0, 0, 0, one};
      mat_post_mul(r);
    end else begin
      v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
      for (int j = 0; j < 3; j++) begin
        acc = v[0] * rot_mat[j] + v[1] * rot_mat[3+j] + v[2] * rot_mat[6+j];
        t[j] = clampl(floor_shr(acc + (64'sd1 << (FB - 1)), FB), -8388608, 8388607);
      end
      o.tx = 24'(t[0]); o.ty = 24'(t[1]); o.tz = 24'(t[2]);
      expected_vertices.push_back(o);
    end
  endtask

  function automatic ravt_pkg::ravt_in_t rnd_item(bit act);
    ravt_pkg::ravt_in_t it;
    it.action = act;
    it.angle_x = 16'($urandom); it.angle_y = 16'($urandom); it.angle_z = 16'($urandom);
    it.vx = 24'($urandom); it.vy = 24'($urandom); it.vz = 24'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      it.vx = 24'($urandom_range(0, 2000) - 1000);
      it.vy = 24'($urandom_range(0, 2000) - 1000);
      it.vz = 24'($urandom_range(0, 2000) - 1000);
    end
    return it;
  endfunction

  function automatic ravt_pkg::ravt_in_t mk(bit act, bit [15:0] ax, bit [15:0] ay,
                                            bit [15:0] az, bit [23:0] x, bit [23:0] y,
                                            bit [23:0] z);
    ravt_pkg::ravt_in_t it;
    it.action = act; it.angle_x = ax; it.angle_y = ay; it.angle_z = az;
    it.vx = x; it.vy = y; it.vz = z;
    return it;
  endfunction

  initial begin
    // identity first, then extremes and quarter turns
    pending_items.push_back(mk(ACT_VTX, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               24'h7FFFFF, 24'h800000, 24'h000100));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h800000, 24'h7FFFFF, 24'hFFFFFF));
    pending_items.push_back(mk(ACT_ROT, 0, 0, 0, 24'hFFFFFF, 24'h7FFFFF, 24'h800000));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h000100, 24'h000200, 24'h000300));
    pending_items.push_back(mk(ACT_ROT, 16'h4000, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h000100, 24'h000100, 24'h000100));
    pending_items.push_back(mk(ACT_ROT, 0, 16'h8000, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    pending_items.push_back(mk(ACT_ROT, 0, 0, 16'hC000, 0, 0, 0));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000));
    pending_items.push_back(mk(ACT_ROT, 16'h2000, 16'h2000, 16'h2000, 0, 0, 0));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000));
    pending_items.push_back(mk(ACT_ROT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));
    pending_items.push_back(mk(ACT_ROT, 16'h003F, 16'h0040, 16'h0041, 0, 0, 0));
    pending_items.push_back(mk(ACT_VTX, 0, 0, 0, 24'h000080, 24'hFFFF80, 24'h000001));
    for (int n = 0; n < 1530; n++)
      pending_items.push_back(rnd_item($urandom_range(0, 3) != 0));
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= $urandom_range(0, 6);
      hold_cycles <= 0;
    end else if (in_valid && !in_ready) begin
    end else begin
      if (in_valid) begin
        predict_item(in_data);
        pending_items.pop_front();
        if (pending_items.size() == 800) hold_req = 1'b1;
      end
      if (hold_req && (expected_vertices.size() != 0 || out_valid)) begin
        in_valid <= 1'b0;
      end else if (in_gap != 0 || pending_items.size() == 0) begin
        hold_req = 1'b0;
        in_valid <= 1'b0;
        if (in_gap != 0) in_gap <= in_gap - 1;
      end else begin
        hold_req = 1'b0;
        in_valid <= 1'b1;
        in_data <= pending_items[0];
        in_gap <= $urandom_range(0, 6);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ravt_pkg::ravt_out_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= $urandom_range(0, 6);
    end else begin
      if (out_valid && out_ready) begin
        if (expected_vertices.size() == 0) begin
          $error("unexpected result item %h", out_data);
          errors++;
        end else begin
          e = expected_vertices.pop_front();
          if (out_data.tx !== e.tx) begin
            $error("tx exp %0d got %0d", e.tx, out_data.tx); errors++;
          end
          if (out_data.ty !== e.ty) begin
            $error("ty exp %0d got %0d", e.ty, out_data.ty); errors++;
          end
          if (out_data.tz !== e.tz) begin
            $error("tz exp %0d got %0d", e.tz, out_data.tz); errors++;
          end
        end
        out_gap <= $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_MAX) begin
      $display("tb_rotation_accumulate_vertex_transform_core NOT OK");
      $finish;
    end
  end

  initial begin
    errors = 0;
    hold_req = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    for (int i = 0; i < 9; i++) rot_mat[i] = (i % 4 == 0) ? (64'sd1 << FB) : 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    wait (expected_vertices.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_vertices.size() == 0)
      $display("tb_rotation_accumulate_vertex_transform_core OK");
    else
      $display("tb_rotation_accumulate_vertex_transform_core NOT OK");
    $finish;
  end

endmodule
